/* hw/rtl/lccp_pkg.sv */
// Shared types and constants for the coefficient compress / bit-pack block.
// No dependencies; every other file in hw/rtl imports this package.
package lccp_pkg;

    // Field and datapath widths
    localparam int COEF_W      = 14;
    localparam int Q_W         = 13;
    localparam int RECIP_W     = 20;
    localparam int D_W         = 4;
    localparam int CODE_W      = 12;
    localparam int BYTE_W      = 8;
    localparam int ACC_W       = 19;
    localparam int CNT_W       = 5;
    localparam int WORK_W      = 32;
    localparam int TOT_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int V_W         = 26;
    localparam int PROD_W      = V_W + RECIP_W;
    localparam int RECIP_SHIFT = 29;
    localparam int EXP_W       = 26;
    localparam int NRES_W      = 2;

    // Code width saturation limits
    localparam logic [D_W-1:0] D_MIN = 4'd8;
    localparam logic [D_W-1:0] D_MAX = 4'd12;

    // Reset values of the configuration registers
    localparam logic [D_W-1:0]     RST_CODED_BITS   = 4'd9;
    localparam logic [Q_W-1:0]     RST_MODULUS      = 13'd7681;
    localparam logic [RECIP_W-1:0] RST_RECIPROCAL   = 20'd69896;
    localparam logic               RST_REDUCE_FIRST = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODED_BITS   = 2'd0,
        CFG_MODULUS      = 2'd1,
        CFG_RECIPROCAL   = 2'd2,
        CFG_REDUCE_FIRST = 2'd3
    } t_cfg_idx;

    // Item modes and result kinds
    localparam logic MODE_COMPRESS = 1'b0;
    localparam logic MODE_UNPACK   = 1'b1;
    localparam logic KIND_BYTE     = 1'b0;
    localparam logic KIND_COEFF    = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [COEF_W-1:0] coefficient;
        logic [BYTE_W-1:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic              out_kind;
        logic [BYTE_W-1:0] out_byte;
        logic [Q_W-1:0]    out_coeff;
        logic              range_error;
        logic              last;
    } t_out_item;

    // Working configuration seen by all stages
    typedef struct packed {
        logic [D_W-1:0]     d;
        logic [CODE_W-1:0]  dmask;
        logic [Q_W-1:0]     q;
        logic [RECIP_W-1:0] recip;
        logic               reduce;
    } t_cfg;

    // Rounded code (compress) or raw byte (unpack) headed for the bit FIFO
    typedef struct packed {
        logic              kind;
        logic              err;
        logic [CODE_W-1:0] val;
    } t_code_item;

    // Up to two raw results of one item: bytes, or codes still to expand
    typedef struct packed {
        logic              kind;
        logic              err;
        logic [NRES_W-1:0] n;
        logic [CODE_W-1:0] v0;
        logic [CODE_W-1:0] v1;
    } t_raw_pair;

endpackage

/* hw/rtl/lccp_front.sv */
// Front end: range check, optional reduction, scaling, then reciprocal multiply.
// Two register stages; depends on lccp_pkg.
module lccp_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lccp_pkg::t_cfg          i_cfg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  lccp_pkg::t_in_item      i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output lccp_pkg::t_code_item    o_item
);
    import lccp_pkg::*;

    logic                r_a_valid;
    logic                r_a_kind;
    logic                r_a_err;
    logic [V_W-1:0]      r_a_v;
    logic [BYTE_W-1:0]   r_a_byte;
    logic                r_b_valid;
    t_code_item          r_b_item;

    logic [COEF_W:0]     twice_q;
    logic                n_err;
    logic                ge_q;
    logic [COEF_W-1:0]   u;
    logic [V_W-1:0]      n_v;
    logic [PROD_W-1:0]   prod;
    logic [CODE_W-1:0]   code;
    t_code_item          n_b_item;
    logic                a_free;
    logic                b_free;
    logic                a_move;

    // Stage A logic: range flag, single reduction, shift by d plus q/2
    always_comb begin
        twice_q = {1'b0, i_cfg.q, 1'b0};
        n_err   = {1'b0, i_item.coefficient} >= twice_q;
        ge_q    = i_item.coefficient >= {1'b0, i_cfg.q};
        u       = (i_cfg.reduce && ge_q) ? (i_item.coefficient - {1'b0, i_cfg.q})
                                         : i_item.coefficient;
        n_v     = ({{(V_W-COEF_W){1'b0}}, u} << i_cfg.d)
                + {{(V_W-Q_W+1){1'b0}}, i_cfg.q[Q_W-1:1]};
    end

    // Stage B logic: reciprocal multiply, drop 29 bits, keep d bits
    always_comb begin
        prod           = {{RECIP_W{1'b0}}, r_a_v} * {{V_W{1'b0}}, i_cfg.recip};
        code           = prod[RECIP_SHIFT +: CODE_W] & i_cfg.dmask;
        n_b_item.kind  = r_a_kind;
        n_b_item.err   = r_a_err;
        n_b_item.val   = (r_a_kind == MODE_COMPRESS) ? code
                                                     : {{(CODE_W-BYTE_W){1'b0}}, r_a_byte};
    end

    // Handshake: each stage loads when it is empty or the one after it frees up
    assign b_free  = !r_b_valid || i_ready;
    assign a_free  = !r_a_valid || b_free;
    assign a_move  = r_a_valid && b_free;
    assign o_ready = a_free;
    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_free) r_a_valid <= i_valid;
            if (b_free) r_b_valid <= r_a_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && a_free) begin
            r_a_kind <= i_item.mode;
            r_a_err  <= n_err;
            r_a_v    <= n_v;
            r_a_byte <= i_item.in_byte;
        end
        if (a_move) begin
            r_b_item <= n_b_item;
        end
    end

endmodule

/* hw/rtl/lccp_bitfifo.sv */
// Shared LSB-first bit FIFO: packs codes into bytes or splits bytes into codes.
// Holds the pending-bit state; depends on lccp_pkg.
module lccp_bitfifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lccp_pkg::t_cfg          i_cfg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  lccp_pkg::t_code_item    i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output lccp_pkg::t_raw_pair     o_pair
);
    import lccp_pkg::*;

    logic [ACC_W-1:0]   r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_c_valid;
    t_raw_pair          r_c_pair;

    logic               is_comp;
    logic [CNT_W-1:0]   sh;
    logic [WORK_W-1:0]  keep_mask;
    logic [WORK_W-1:0]  work;
    logic [TOT_W-1:0]   total;
    logic [TOT_W-1:0]   step;
    logic [TOT_W-1:0]   rem1;
    logic [TOT_W-1:0]   consumed;
    logic [WORK_W-1:0]  shifted;
    logic [WORK_W-1:0]  work_hi;
    logic [NRES_W-1:0]  n;
    t_raw_pair          n_pair;
    logic [ACC_W-1:0]   n_acc;
    logic [CNT_W-1:0]   n_cnt;
    logic               c_free;
    logic               take;

    // Merge the new bits above the pending ones and count what comes out
    always_comb begin
        is_comp   = (i_item.kind == MODE_COMPRESS);
        // compress keeps at most the seven oldest pending bits
        sh        = (is_comp && (r_cnt > CNT_W'(7))) ? CNT_W'(7) : r_cnt;
        keep_mask = (WORK_W'(1) << sh) - WORK_W'(1);
        work      = ({{(WORK_W-ACC_W){1'b0}}, r_acc} & keep_mask)
                  | ({{(WORK_W-CODE_W){1'b0}}, i_item.val} << sh);
        step      = is_comp ? TOT_W'(BYTE_W) : {{(TOT_W-D_W){1'b0}}, i_cfg.d};
        // a code adds d bits, a byte adds eight
        total     = {1'b0, sh} + (is_comp ? {{(TOT_W-D_W){1'b0}}, i_cfg.d}
                                          : TOT_W'(BYTE_W));
        rem1      = total - step;
        if (total < step)      n = 2'd0;
        else if (rem1 < step)  n = 2'd1;
        else                   n = 2'd2;
        case (n)
            2'd1:    consumed = step;
            2'd2:    consumed = step << 1;
            default: consumed = '0;
        endcase
        shifted   = work >> consumed;
        work_hi   = work >> step;
        n_acc     = shifted[ACC_W-1:0];
        n_cnt     = CNT_W'(total - consumed);

        n_pair.kind = i_item.kind;
        n_pair.err  = i_item.err;
        n_pair.n    = n;
        if (is_comp) begin
            n_pair.v0 = {{(CODE_W-BYTE_W){1'b0}}, work[BYTE_W-1:0]};
            n_pair.v1 = {{(CODE_W-BYTE_W){1'b0}}, work[2*BYTE_W-1:BYTE_W]};
        end else begin
            n_pair.v0 = work[CODE_W-1:0] & i_cfg.dmask;
            n_pair.v1 = work_hi[CODE_W-1:0] & i_cfg.dmask;
        end
    end

    // Items that give no result drop out here
    assign c_free  = !r_c_valid || i_ready;
    assign take    = i_valid && c_free;
    assign o_ready = c_free;
    assign o_valid = r_c_valid;
    assign o_pair  = r_c_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_cnt     <= '0;
            r_c_valid <= 1'b0;
        end else if (take) begin
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_c_valid <= (n != 2'd0);
        end else if (c_free) begin
            r_c_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_c_pair <= n_pair;
    end

endmodule

/* hw/rtl/lccp_expand.sv */
// Expands unpacked codes to coefficients and sends the results out one at a time.
// Holds the output pair register; depends on lccp_pkg.
module lccp_expand (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lccp_pkg::t_cfg          i_cfg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  lccp_pkg::t_raw_pair     i_pair,
    output logic                    o_valid,
    input  logic                    i_ready,
    output lccp_pkg::t_out_item     o_item
);
    import lccp_pkg::*;

    logic               r_valid;
    logic               r_sel;
    logic [NRES_W-1:0]  r_n;
    t_out_item          r_res0;
    t_out_item          r_res1;

    logic [EXP_W-1:0]   half;
    logic [EXP_W-1:0]   e0_full;
    logic [EXP_W-1:0]   e1_full;
    t_out_item          n_res0;
    t_out_item          n_res1;
    t_out_item          cur;
    logic               out_last;
    logic               pair_free;

    // (t * q + 2^(d-1)) >> d for both codes
    always_comb begin
        half    = EXP_W'(1) << (i_cfg.d - D_W'(1));
        e0_full = (({{(EXP_W-CODE_W){1'b0}}, i_pair.v0} * {{(EXP_W-Q_W){1'b0}}, i_cfg.q})
                  + half) >> i_cfg.d;
        e1_full = (({{(EXP_W-CODE_W){1'b0}}, i_pair.v1} * {{(EXP_W-Q_W){1'b0}}, i_cfg.q})
                  + half) >> i_cfg.d;
    end

    // Shape the two result words
    always_comb begin
        n_res0.out_kind    = i_pair.kind;
        n_res1.out_kind    = i_pair.kind;
        n_res0.last        = 1'b0;
        n_res1.last        = 1'b0;
        if (i_pair.kind == KIND_BYTE) begin
            n_res0.out_byte    = i_pair.v0[BYTE_W-1:0];
            n_res1.out_byte    = i_pair.v1[BYTE_W-1:0];
            n_res0.out_coeff   = '0;
            n_res1.out_coeff   = '0;
            n_res0.range_error = i_pair.err;
            n_res1.range_error = i_pair.err;
        end else begin
            n_res0.out_byte    = '0;
            n_res1.out_byte    = '0;
            n_res0.out_coeff   = e0_full[Q_W-1:0];
            n_res1.out_coeff   = e1_full[Q_W-1:0];
            n_res0.range_error = 1'b0;
            n_res1.range_error = 1'b0;
        end
    end

    // Output serializer
    assign out_last  = r_sel || (r_n == 2'd1);
    assign pair_free = !r_valid || (i_ready && out_last);
    assign o_ready   = pair_free;
    assign o_valid   = r_valid;

    always_comb begin
        cur      = r_sel ? r_res1 : r_res0;
        cur.last = out_last;
        o_item   = cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (i_valid && pair_free) begin
            r_valid <= 1'b1;
            r_sel   <= 1'b0;
        end else if (r_valid && i_ready) begin
            if (out_last) begin
                r_valid <= 1'b0;
                r_sel   <= 1'b0;
            end else begin
                r_sel   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && pair_free) begin
            r_n    <= i_pair.n;
            r_res0 <= n_res0;
            r_res1 <= n_res1;
        end
    end

endmodule

/* hw/rtl/lattice_coeff_compress_pack.sv */
// Top level of the lattice coefficient compress / bit-pack block.
// Holds the configuration registers; uses lccp_pkg, lccp_front, lccp_bitfifo, lccp_expand.
//
//  channel   direction  handshake                    payload
//  --------  ---------  ---------------------------  ---------------------------
//  in        input      i_in_valid / o_in_ready      i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready    o_out_data (t_out_item)
//  cfg       input      i_cfg_we                     i_cfg_index, i_cfg_data
//
// One item is taken per cycle while no stage stalls; its first result goes through
// stage A, stage B, the bit FIFO and the output pair register. The output port
// carries one result per cycle; a two-result item holds the pipeline at the pair register.
// Reset is synchronous, active low, and clears the pending bits, the stage
// valids and the registers to their defaults. A stall on the output backs up
// stage by stage to o_in_ready; items with no result leave at the bit FIFO.
module lattice_coeff_compress_pack (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lccp_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lccp_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [lccp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lccp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lccp_pkg::*;

    logic [D_W-1:0]      r_coded_bits;
    logic [Q_W-1:0]      r_modulus;
    logic [RECIP_W-1:0]  r_reciprocal;
    logic                r_reduce_first;

    logic [D_W-1:0]      d_eff;
    logic [CODE_W:0]     mask_full;
    t_cfg                cfg;

    logic                code_valid;
    logic                code_ready;
    t_code_item          code_item;
    logic                pair_valid;
    logic                pair_ready;
    t_raw_pair           pair;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coded_bits   <= RST_CODED_BITS;
            r_modulus      <= RST_MODULUS;
            r_reciprocal   <= RST_RECIPROCAL;
            r_reduce_first <= RST_REDUCE_FIRST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CODED_BITS:   r_coded_bits   <= i_cfg_data[D_W-1:0];
                CFG_MODULUS:      r_modulus      <= i_cfg_data[Q_W-1:0];
                CFG_RECIPROCAL:   r_reciprocal   <= i_cfg_data[RECIP_W-1:0];
                CFG_REDUCE_FIRST: r_reduce_first <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Code width clamped to 8..12, and its mask
    always_comb begin
        if (r_coded_bits < D_MIN)      d_eff = D_MIN;
        else if (r_coded_bits > D_MAX) d_eff = D_MAX;
        else                           d_eff = r_coded_bits;
        mask_full  = ((CODE_W+1)'(1) << d_eff) - (CODE_W+1)'(1);
        cfg.d      = d_eff;
        cfg.dmask  = mask_full[CODE_W-1:0];
        cfg.q      = r_modulus;
        cfg.recip  = r_reciprocal;
        cfg.reduce = r_reduce_first;
    end

    lccp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .o_valid (code_valid),
        .i_ready (code_ready),
        .o_item  (code_item)
    );

    lccp_bitfifo u_bitfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (code_valid),
        .o_ready (code_ready),
        .i_item  (code_item),
        .o_valid (pair_valid),
        .i_ready (pair_ready),
        .o_pair  (pair)
    );

    lccp_expand u_expand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (pair_valid),
        .o_ready (pair_ready),
        .i_pair  (pair),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

endmodule
